// ===== src/rti_pkg.sv =====
// shared types and constants for the ray triangle intersection unit
package rti_pkg;

  localparam int CW = 32;
  localparam int EW = CW + 1;
  localparam int XW = 2 * EW;
  localparam int VW = XW + 1;
  localparam int SPLIT = 34;
  localparam int LW = XW + 2;
  localparam int NW = 102;
  localparam int QB = 32;
  localparam int BW = 17;

  localparam int NREG = 8;
  localparam int RI_W = 3;
  localparam int CFG_IDX_W = 4;

  localparam logic [RI_W-1:0] CFG_ORG_X = 3'd0;
  localparam logic [RI_W-1:0] CFG_ORG_Y = 3'd1;
  localparam logic [RI_W-1:0] CFG_ORG_Z = 3'd2;
  localparam logic [RI_W-1:0] CFG_DIR_X = 3'd3;
  localparam logic [RI_W-1:0] CFG_DIR_Y = 3'd4;
  localparam logic [RI_W-1:0] CFG_DIR_Z = 3'd5;
  localparam logic [RI_W-1:0] CFG_T_MIN = 3'd6;
  localparam logic [RI_W-1:0] CFG_T_MAX = 3'd7;

  localparam logic [CW-1:0] RAY_RESET [NREG] = '{
    32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd65536, 32'd0, 32'd2147483647
  };

  typedef struct packed {
    logic signed [CW-1:0] va_x;
    logic signed [CW-1:0] va_y;
    logic signed [CW-1:0] va_z;
    logic signed [CW-1:0] vb_x;
    logic signed [CW-1:0] vb_y;
    logic signed [CW-1:0] vb_z;
    logic signed [CW-1:0] vc_x;
    logic signed [CW-1:0] vc_y;
    logic signed [CW-1:0] vc_z;
    logic                 tri_last;
  } rti_in_t;

  typedef struct packed {
    logic                 hit;
    logic signed [CW-1:0] hit_distance;
    logic [BW-1:0]        bary_one;
    logic [BW-1:0]        bary_two;
    logic                 result_last;
  } rti_out_t;

endpackage

// ===== src/rti_div.sv =====
// pipelined restoring divider: |num| << frac / |den|, one quotient bit per stage
module rti_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic                           clk,
  input  logic                           en,
  input  logic signed [rti_pkg::NW-1:0]  num,
  input  logic signed [rti_pkg::NW-1:0]  den,
  output logic [rti_pkg::QB-1:0]         q_mag,
  output logic                           q_ovf,
  output logic                           q_neg
);
  import rti_pkg::*;

  localparam int RW = NW + QB;

  logic [NW-1:0] nm_r;
  logic [NW-1:0] dm_r;
  logic          sg_r;

  logic [RW-1:0] rem_r [QB+1];
  logic [NW-1:0] den_r [QB+1];
  logic [QB-1:0] quo_r [QB+1];
  logic          ovf_r [QB+1];
  logic          neg_r [QB+1];

  logic [RW-1:0] rem0_nxt;

  always_comb begin
    rem0_nxt = RW'(nm_r) << FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nm_r <= num[NW-1] ? NW'(-num) : NW'(num);
      dm_r <= den[NW-1] ? NW'(-den) : NW'(den);
      sg_r <= num[NW-1] ^ den[NW-1];
      rem_r[0] <= rem0_nxt;
      den_r[0] <= dm_r;
      quo_r[0] <= '0;
      ovf_r[0] <= rem0_nxt >= (RW'(dm_r) << QB);
      neg_r[0] <= sg_r;
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_step
    logic [RW-1:0] sh;
    logic          ge;
    always_comb begin
      sh = RW'(den_r[k]) << (QB - 1 - k);
      ge = rem_r[k] >= sh;
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1] <= ge ? rem_r[k] - sh : rem_r[k];
        quo_r[k+1] <= {quo_r[k][QB-2:0], ge};
        den_r[k+1] <= den_r[k];
        ovf_r[k+1] <= ovf_r[k];
        neg_r[k+1] <= neg_r[k];
      end
    end
  end

  assign q_mag = quo_r[QB];
  assign q_ovf = ovf_r[QB];
  assign q_neg = neg_r[QB];

endmodule

// ===== src/ray_triangle_intersect_unit.sv =====
// top level of the ray triangle intersection unit
// usage:
//   the ray (origin, direction, t interval, signed q16.16) is written through
//   the cfg port (valid/ready, ready always high); the user must write it only
//   while no item is in flight, as the block does not enforce this. each input
//   item is one triangle of three vertices plus a last flag; each item gives
//   exactly one result item with hit, t, b1, b2 and the last flag.
// stages: six stages of edge, cross product and dot product math, the
//   pipelined dividers (one quotient bit per stage), and the output register.
// throughput: one item per cycle unless stalled; all stages advance together.
// stall: when the output holds an item and out_stall is high, the whole
//   pipeline freezes and in_stall is raised; nothing is lost or repeated.
// reset: rst_n (synchronous) empties the pipeline and loads the ray registers
//   with origin 0, direction +z, t interval 0 to the largest positive value.
module ray_triangle_intersect_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  rti_pkg::rti_in_t                   in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output rti_pkg::rti_out_t                  out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [rti_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rti_pkg::CW-1:0]             cfg_data
);
  import rti_pkg::*;

  localparam int NST = 6;
  localparam int DLAT = QB + 2;
  localparam int SQ = QB + 1;
  localparam int NDOT = 4;
  localparam int DOT_DIV = 0;
  localparam int DOT_SP = 1;
  localparam int DOT_DQ = 2;
  localparam int DOT_EQ = 3;
  localparam int NX1 [3] = '{1, 2, 0};
  localparam int NX2 [3] = '{2, 0, 1};
  localparam logic signed [SQ-1:0] ONE = SQ'(1) << FRAC_BITS;

  typedef struct packed {
    logic vld;
    logic last;
    logic nz;
  } rti_sb_t;

  logic                 en;
  logic signed [CW-1:0] ray_r [NREG];

  logic signed [CW-1:0] va [3];
  logic signed [CW-1:0] vb [3];
  logic signed [CW-1:0] vc [3];
  logic signed [EW-1:0] dir [3];

  logic                 vld_r  [NST];
  logic                 last_r [NST];

  logic signed [EW-1:0] e1_1_r [3];
  logic signed [EW-1:0] e2_1_r [3];
  logic signed [EW-1:0] s_1_r  [3];
  logic signed [EW-1:0] e1_2_r [3];
  logic signed [EW-1:0] e2_2_r [3];
  logic signed [EW-1:0] s_2_r  [3];
  logic signed [EW-1:0] e1_3_r [3];
  logic signed [EW-1:0] e2_3_r [3];
  logic signed [EW-1:0] s_3_r  [3];
  logic signed [XW-1:0] pa_r [3];
  logic signed [XW-1:0] pb_r [3];
  logic signed [XW-1:0] qa_r [3];
  logic signed [XW-1:0] qb_r [3];
  logic signed [VW-1:0] p_r  [3];
  logic signed [VW-1:0] q_r  [3];

  logic signed [VW-1:0] wop [NDOT][3];
  logic signed [EW-1:0] nop [NDOT][3];
  logic signed [XW-1:0] ph_r [NDOT][3];
  logic signed [LW-1:0] pl_r [NDOT][3];
  logic signed [NW-1:0] term_r [NDOT][3];
  logic signed [NW-1:0] dot_r [NDOT];

  rti_sb_t              sb_r [DLAT];
  logic [QB-1:0]        qm [3];
  logic                 qo [3];
  logic                 qn [3];
  logic signed [SQ-1:0] qv [3];

  logic signed [SQ:0]   bsum;
  logic signed [SQ-1:0] tmin_x;
  logic signed [SQ-1:0] tmax_x;
  logic                 b1_ok;
  logic                 b2_ok;
  logic                 t_ok;
  logic                 hit_nxt;

  logic                 out_valid_r;
  rti_out_t             out_data_r;

  assign en        = !out_valid_r || !out_stall;
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ray registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NREG; i++) ray_r[i] <= RAY_RESET[i];
    end else if (cfg_valid && cfg_index < CFG_IDX_W'(NREG)) begin
      ray_r[cfg_index[RI_W-1:0]] <= $signed(cfg_data);
    end
  end

  always_comb begin
    va[0] = in_data.va_x;  va[1] = in_data.va_y;  va[2] = in_data.va_z;
    vb[0] = in_data.vb_x;  vb[1] = in_data.vb_y;  vb[2] = in_data.vb_z;
    vc[0] = in_data.vc_x;  vc[1] = in_data.vc_y;  vc[2] = in_data.vc_z;
    dir[0] = EW'(ray_r[CFG_DIR_X]);
    dir[1] = EW'(ray_r[CFG_DIR_Y]);
    dir[2] = EW'(ray_r[CFG_DIR_Z]);
  end

  // valid and last travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NST; i++) vld_r[i] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int i = 1; i < NST; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      last_r[0] <= in_data.tri_last;
      for (int i = 1; i < NST; i++) last_r[i] <= last_r[i-1];
    end
  end

  // edges, origin offset, cross product terms
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        e1_1_r[i] <= EW'(vb[i]) - EW'(va[i]);
        e2_1_r[i] <= EW'(vc[i]) - EW'(va[i]);
        s_1_r[i]  <= EW'(ray_r[i]) - EW'(va[i]);
        pa_r[i] <= XW'(dir[NX1[i]]) * XW'(e2_1_r[NX2[i]]);
        pb_r[i] <= XW'(dir[NX2[i]]) * XW'(e2_1_r[NX1[i]]);
        qa_r[i] <= XW'(s_1_r[NX1[i]]) * XW'(e1_1_r[NX2[i]]);
        qb_r[i] <= XW'(s_1_r[NX2[i]]) * XW'(e1_1_r[NX1[i]]);
        e1_2_r[i] <= e1_1_r[i];
        e2_2_r[i] <= e2_1_r[i];
        s_2_r[i]  <= s_1_r[i];
        p_r[i] <= VW'(pa_r[i]) - VW'(pb_r[i]);
        q_r[i] <= VW'(qa_r[i]) - VW'(qb_r[i]);
        e1_3_r[i] <= e1_2_r[i];
        e2_3_r[i] <= e2_2_r[i];
        s_3_r[i]  <= s_2_r[i];
      end
    end
  end

  // dot product operands: wide side split in two halves
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      wop[DOT_DIV][i] = p_r[i];  nop[DOT_DIV][i] = e1_3_r[i];
      wop[DOT_SP][i]  = p_r[i];  nop[DOT_SP][i]  = s_3_r[i];
      wop[DOT_DQ][i]  = q_r[i];  nop[DOT_DQ][i]  = dir[i];
      wop[DOT_EQ][i]  = q_r[i];  nop[DOT_EQ][i]  = e2_3_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < NDOT; j++) begin
        for (int i = 0; i < 3; i++) begin
          ph_r[j][i] <= XW'($signed(wop[j][i][VW-1:SPLIT])) * XW'(nop[j][i]);
          pl_r[j][i] <= LW'($signed({1'b0, wop[j][i][SPLIT-1:0]})) * LW'(nop[j][i]);
          term_r[j][i] <= (NW'(ph_r[j][i]) <<< SPLIT) + NW'(pl_r[j][i]);
        end
        dot_r[j] <= term_r[j][0] + term_r[j][1] + term_r[j][2];
      end
    end
  end

  // b1, b2 and t quotients
  for (genvar g = 0; g < 3; g++) begin : g_div
    rti_div #(
      .FRAC_BITS (FRAC_BITS)
    ) u_div (
      .clk   (clk),
      .en    (en),
      .num   (dot_r[g + 1]),
      .den   (dot_r[DOT_DIV]),
      .q_mag (qm[g]),
      .q_ovf (qo[g]),
      .q_neg (qn[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DLAT; i++) sb_r[i] <= '0;
    end else if (en) begin
      sb_r[0] <= '{vld: vld_r[NST-1], last: last_r[NST-1], nz: dot_r[DOT_DIV] != '0};
      for (int i = 1; i < DLAT; i++) sb_r[i] <= sb_r[i-1];
    end
  end

  // hit tests
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qv[i] = qn[i] ? -$signed({1'b0, qm[i]}) : $signed({1'b0, qm[i]});
    end
    bsum   = (SQ+1)'(qv[0]) + (SQ+1)'(qv[1]);
    tmin_x = SQ'(ray_r[CFG_T_MIN]);
    tmax_x = SQ'(ray_r[CFG_T_MAX]);
    b1_ok  = !qo[0] && !qv[0][SQ-1] && qv[0] <= ONE;
    b2_ok  = !qo[1] && !qv[1][SQ-1] && bsum <= (SQ+1)'(ONE);
    t_ok   = !qo[2] && qv[2] >= tmin_x && qv[2] <= tmax_x;
    hit_nxt = sb_r[DLAT-1].nz && b1_ok && b2_ok && t_ok;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= sb_r[DLAT-1].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r.hit          <= hit_nxt;
      out_data_r.hit_distance <= hit_nxt ? qv[2][CW-1:0] : '0;
      out_data_r.bary_one     <= hit_nxt ? qv[0][BW-1:0] : '0;
      out_data_r.bary_two     <= hit_nxt ? qv[1][BW-1:0] : '0;
      out_data_r.result_last  <= sb_r[DLAT-1].last;
    end
  end

endmodule

// ===== src/rti_check.sv =====
// port checker for the ray triangle intersection unit and its bind
module rti_check (
  input logic              clk,
  input logic              rst_n,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input rti_pkg::rti_out_t out_data
);
  import rti_pkg::*;

  // stalled result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result item changed");

  // input is only held back by a stalled full output
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output back pressure");

  // a miss carries zero distance and zero barycentrics
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.hit |->
      out_data.hit_distance == '0 && out_data.bary_one == '0 && out_data.bary_two == '0)
    else $error("miss item with nonzero fields");

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result item right after reset");

endmodule

bind ray_triangle_intersect_unit rti_check u_rti_check (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ===== test/ray_triangle_intersect_unit_tb.sv =====
// testbench for the ray triangle intersection unit: directed and random triangles checked against a predictor
module ray_triangle_intersect_unit_tb;
  import rti_pkg::*;

  localparam int FRAC = 16;
  localparam int LAT = 41;
  localparam int WATCHDOG = 20000;

  typedef logic signed [199:0] wide_t;

  class hit_scoreboard;
    logic [CW-1:0] ray [NREG];
    rti_out_t pending_hits [$];
    int mismatches;

    function new();
      for (int i = 0; i < NREG; i++) ray[i] = RAY_RESET[i];
      mismatches = 0;
    endfunction

    function void set_reg(int idx, logic [CW-1:0] val);
      if (idx < NREG) ray[idx] = val;
    endfunction

    function wide_t qdiv(wide_t num, wide_t den);
      wide_t q;
      logic neg;
      neg = (num < 0) != (den < 0);
      if (num < 0) num = -num;
      if (den < 0) den = -den;
      q = (num <<< FRAC) / den;
      return neg ? -q : q;
    endfunction

    function void note_triangle(rti_in_t tri_in);
      wide_t o[3], d[3], a[3], b[3], c[3], e1[3], e2[3], p[3], s[3], q[3];
      wide_t dv, b1, b2, t, one;
      rti_out_t r;
      o[0] = $signed(ray[CFG_ORG_X]); o[1] = $signed(ray[CFG_ORG_Y]);
      o[2] = $signed(ray[CFG_ORG_Z]);
      d[0] = $signed(ray[CFG_DIR_X]); d[1] = $signed(ray[CFG_DIR_Y]);
      d[2] = $signed(ray[CFG_DIR_Z]);
      a[0] = tri_in.va_x; a[1] = tri_in.va_y; a[2] = tri_in.va_z;
      b[0] = tri_in.vb_x; b[1] = tri_in.vb_y; b[2] = tri_in.vb_z;
      c[0] = tri_in.vc_x; c[1] = tri_in.vc_y; c[2] = tri_in.vc_z;
      one = wide_t'(1) <<< FRAC;
      for (int i = 0; i < 3; i++) begin
        e1[i] = b[i] - a[i];
        e2[i] = c[i] - a[i];
        s[i] = o[i] - a[i];
      end
      p[0] = d[1] * e2[2] - d[2] * e2[1];
      p[1] = d[2] * e2[0] - d[0] * e2[2];
      p[2] = d[0] * e2[1] - d[1] * e2[0];
      q[0] = s[1] * e1[2] - s[2] * e1[1];
      q[1] = s[2] * e1[0] - s[0] * e1[2];
      q[2] = s[0] * e1[1] - s[1] * e1[0];
      dv = p[0] * e1[0] + p[1] * e1[1] + p[2] * e1[2];
      r = '0;
      r.result_last = tri_in.tri_last;
      if (dv != 0) begin
        b1 = qdiv(s[0] * p[0] + s[1] * p[1] + s[2] * p[2], dv);
        if (b1 >= 0 && b1 <= one) begin
          b2 = qdiv(d[0] * q[0] + d[1] * q[1] + d[2] * q[2], dv);
          if (b2 >= 0 && b1 + b2 <= one) begin
            t = qdiv(e2[0] * q[0] + e2[1] * q[1] + e2[2] * q[2], dv);
            if (t >= wide_t'($signed(ray[CFG_T_MIN])) &&
                t <= wide_t'($signed(ray[CFG_T_MAX]))) begin
              r.hit = 1'b1;
              r.hit_distance = t[31:0];
              r.bary_one = b1[BW-1:0];
              r.bary_two = b2[BW-1:0];
            end
          end
        end
      end
      pending_hits.push_back(r);
    endfunction

    function void check_result(rti_out_t got);
      rti_out_t want;
      if (pending_hits.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item %h", got);
        return;
      end
      want = pending_hits.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch: expected hit=%b t=%h b1=%h b2=%h last=%b",
                   want.hit, want.hit_distance, want.bary_one, want.bary_two,
                   want.result_last);
          $display("          got      hit=%b t=%h b1=%h b2=%h last=%b",
                   got.hit, got.hit_distance, got.bary_one, got.bary_two,
                   got.result_last);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  rti_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  rti_out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CW-1:0] cfg_data = '0;

  hit_scoreboard sb = new();
  int idle_cycles = 0;
  bit long_hold = 1'b0;
  bit stall_random = 1'b1;

  always #5 clk = ~clk;

  ray_triangle_intersect_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
    if (rst_n && ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                  (cfg_valid && cfg_ready)))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // receiver stall pattern
  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (long_hold) out_stall <= 1'b1;
      else if (!stall_random) out_stall <= 1'b0;
      else begin
        n = $urandom_range(0, 9);
        out_stall <= (n < 3);
      end
    end
  end

  function automatic logic [CW-1:0] rand_coord(int mode);
    case (mode)
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      default: return $signed($urandom_range(0, 16 << 16)) - (8 << 16);
    endcase
  endfunction

  task automatic write_reg(int idx, logic [CW-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_IDX_W'(idx);
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (sb.pending_hits.size() != 0) @(posedge clk);
    repeat (LAT + 5) @(posedge clk);
  endtask

  // one triangle; gap inserts idle cycles before it
  task automatic send_tri(rti_in_t tri_in, int gap);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= tri_in;
    do @(posedge clk); while (in_stall);
    sb.note_triangle(tri_in);
  endtask

  task automatic end_burst();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // triangle around the ray with small jitter so hits are common
  function automatic rti_in_t near_tri(int mode);
    rti_in_t t;
    int sz;
    sz = $urandom_range(1, 4) << 16;
    t.va_x = -sz + $signed($urandom_range(0, 1 << 15)) - (1 << 14);
    t.va_y = -sz + $signed($urandom_range(0, 1 << 15));
    t.va_z = $signed($urandom_range(0, 8 << 16)) - (2 << 16);
    t.vb_x = sz + $signed($urandom_range(0, 1 << 15));
    t.vb_y = -sz;
    t.vb_z = t.va_z + $signed($urandom_range(0, 1 << 16)) - (1 << 15);
    t.vc_x = $signed($urandom_range(0, 1 << 16)) - (1 << 15);
    t.vc_y = sz;
    t.vc_z = t.va_z + $signed($urandom_range(0, 1 << 16)) - (1 << 15);
    t.tri_last = $urandom_range(0, 1);
    if (mode == 1) begin
      t.va_x = rand_coord(0); t.vb_y = rand_coord(0); t.vc_z = rand_coord(0);
    end else if (mode == 2) begin
      t.vb_x = t.va_x; t.vb_y = t.va_y; t.vb_z = t.va_z;
    end
    return t;
  endfunction

  function automatic rti_in_t wild_tri();
    rti_in_t t;
    int m;
    m = $urandom_range(0, 2);
    t.va_x = rand_coord(m); t.va_y = rand_coord(m); t.va_z = rand_coord(m);
    t.vb_x = rand_coord(m); t.vb_y = rand_coord(m); t.vb_z = rand_coord(m);
    t.vc_x = rand_coord(m); t.vc_y = rand_coord(m); t.vc_z = rand_coord(m);
    t.tri_last = $urandom_range(0, 1);
    return t;
  endfunction

  task automatic random_phase(int count);
    int sent, burst;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 20);
      for (int k = 0; k < burst && sent < count; k++) begin
        int r;
        r = $urandom_range(0, 9);
        send_tri(r < 7 ? near_tri(r == 0 ? 1 : 0) : (r == 9 ? near_tri(2) : wild_tri()), 0);
        sent++;
      end
      end_burst();
      repeat ($urandom_range(0, 6)) @(negedge clk);
    end
    end_burst();
  endtask

  initial begin
    rti_in_t t;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: reset ray, hits, edges, parallel ray, extremes
    t = '0;
    t.va_x = -(1 << 16); t.va_y = -(1 << 16); t.va_z = 2 << 16;
    t.vb_x = 1 << 16; t.vb_y = -(1 << 16); t.vb_z = 2 << 16;
    t.vc_x = 0; t.vc_y = 1 << 16; t.vc_z = 2 << 16;
    send_tri(t, 0);
    t.tri_last = 1'b1; t.va_z = -(3 << 16); t.vb_z = t.va_z; t.vc_z = t.va_z;
    send_tri(t, 0);
    t.va_x = 0; t.va_y = 0; t.va_z = 1 << 16; t.vb_z = 1 << 16; t.vc_z = 1 << 16;
    t.vb_x = 1 << 16; t.vb_y = 0; t.vc_x = 0; t.vc_y = 1 << 16;
    send_tri(t, 0);
    t.vb_x = 0; t.vb_y = 0; t.va_x = -(1 << 16);
    send_tri(t, 0);
    t.va_x = 0; t.va_y = 0; t.va_z = 0; t.vb_x = 1 << 16; t.vb_y = 0; t.vb_z = 0;
    t.vc_x = 0; t.vc_y = 0; t.vc_z = 1 << 16;
    send_tri(t, 0);
    t = '1;
    send_tri(t, 0);
    t = {{9{32'h80000000}}, 1'b0};
    send_tri(t, 0);
    t = {32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
         32'h7fffffff, 32'h80000000, 32'h80000000, 32'h00000001, 1'b1};
    send_tri(t, 0);
    for (int k = 0; k < 8; k++) send_tri(near_tri(k % 3), 0);
    end_burst();
    drain();

    // back pressure: hold the receiver while triangles keep coming
    long_hold = 1'b1;
    fork
      begin
        for (int k = 0; k < 80; k++) send_tri(near_tri(0), 0);
        end_burst();
      end
      begin
        repeat (150) @(posedge clk);
        long_hold = 1'b0;
      end
    join
    drain();

    random_phase(150);
    drain();

    write_reg(CFG_ORG_X, 32'h00008000);
    write_reg(CFG_ORG_Y, 32'hffff4000);
    write_reg(CFG_ORG_Z, 32'hfffe0000);
    write_reg(CFG_DIR_X, 32'h00002000);
    write_reg(CFG_DIR_Y, 32'hffffe000);
    write_reg(CFG_DIR_Z, 32'h00018000);
    write_reg(CFG_T_MIN, 32'h00010000);
    write_reg(CFG_T_MAX, 32'h00040000);
    write_reg(NREG + 3, 32'h12345678);
    random_phase(150);
    drain();

    write_reg(CFG_ORG_X, 32'h7fffffff);
    write_reg(CFG_ORG_Y, 32'h80000000);
    write_reg(CFG_ORG_Z, 32'h80000000);
    write_reg(CFG_DIR_X, 32'h80000000);
    write_reg(CFG_DIR_Y, 32'h7fffffff);
    write_reg(CFG_DIR_Z, 32'h80000000);
    write_reg(CFG_T_MIN, 32'h80000000);
    write_reg(CFG_T_MAX, 32'h7fffffff);
    random_phase(80);
    drain();

    write_reg(CFG_ORG_X, 32'h0);
    write_reg(CFG_ORG_Y, 32'h0);
    write_reg(CFG_ORG_Z, 32'hfffc0000);
    write_reg(CFG_DIR_X, 32'h0);
    write_reg(CFG_DIR_Y, 32'h0);
    write_reg(CFG_DIR_Z, 32'hffff0000);
    write_reg(CFG_T_MIN, 32'h80000000);
    write_reg(CFG_T_MAX, 32'h0);
    stall_random = 1'b0;
    random_phase(60);
    stall_random = 1'b1;
    random_phase(60);
    drain();

    if (sb.mismatches == 0 && sb.pending_hits.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== ray_triangle_intersect_unit.f =====
src/rti_pkg.sv
src/rti_div.sv
src/ray_triangle_intersect_unit.sv
src/rti_check.sv
test/ray_triangle_intersect_unit_tb.sv
